### design/stnt_pkg.sv
// Shared types and constants for the spatial table with nearest-threat search.
// Word layouts, command and status codes, and the controller/datapath interface.
// No dependencies.
package stnt_pkg;

	localparam int COORD_BITS  = 16;
	localparam int KIND_BITS   = 3;
	localparam int UID_BITS    = 32;
	localparam int RAD_BITS    = 16;
	localparam int DIST_BITS   = 2 * COORD_BITS + 2;

	localparam logic [KIND_BITS-1:0] KIND_OBSTACLE = '0;

	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_PRUNE   = 2'd1,
		CMD_CLOSEST = 2'd2,
		CMD_LIST    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		EMIT_NONE  = 2'd0,
		EMIT_EMPTY = 2'd1,
		EMIT_PUSH  = 2'd2,
		EMIT_ENTRY = 2'd3
	} emit_t;

	typedef struct packed {
		cmd_t                          command;
		logic [KIND_BITS-1:0]          entity_type;
		logic signed [COORD_BITS-1:0]  pos_x;
		logic signed [COORD_BITS-1:0]  pos_y;
		logic signed [COORD_BITS-1:0]  pos_z;
		logic [RAD_BITS-1:0]           radius;
	} in_word_t;

	typedef struct packed {
		status_t                       status;
		logic                          found;
		logic [UID_BITS-1:0]           uid;
		logic [KIND_BITS-1:0]          kind;
		logic signed [COORD_BITS-1:0]  out_x;
		logic signed [COORD_BITS-1:0]  out_y;
		logic signed [COORD_BITS-1:0]  out_z;
		logic [RAD_BITS-1:0]           safety_radius;
		logic                          active;
		logic                          last;
	} out_word_t;

	typedef struct packed {
		logic [UID_BITS-1:0]           uid;
		logic [KIND_BITS-1:0]          kind;
		logic signed [COORD_BITS-1:0]  x;
		logic signed [COORD_BITS-1:0]  y;
		logic signed [COORD_BITS-1:0]  z;
		logic [RAD_BITS-1:0]           radius;
		logic                          active;
	} entry_t;

	typedef struct packed {
		logic     load;
		logic     walk_clear;
		logic     issue;
		logic     push_commit;
		logic     prune_commit;
		emit_t    emit;
		status_t  emit_status;
		logic     emit_last;
	} ctrl_t;

	typedef struct packed {
		cmd_t  cmd;
		logic  out_free;
		logic  busy;
		logic  full;
		logic  hit;
		logic  any;
		logic  rd_match;
	} stat_t;

	function automatic logic [COORD_BITS-1:0] abs_diff(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic [COORD_BITS:0] d;
		logic [COORD_BITS:0] m;
		d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		m = d[COORD_BITS] ? (~d + 1'b1) : d;
		return m[COORD_BITS-1:0];
	endfunction

endpackage

### design/spatial_table_nearest_threat.sv
// Top level of the spatial entry table with nearest-threat search.
// Depends on stnt_pkg, stnt_ctrl, stnt_dp and stnt_ram.
//
// One command word is taken at a time; the next is accepted once the current
// command has handed its last result word to the output register. Prune,
// closest and list walk the N stored entries through the single read port of
// the entry RAM, one entry per cycle. For closest the distance pipeline then
// drains, and the winning entry is read back when one is found; list reads the
// entries again up to and including the last match. Output stalls hold the
// command up. There is no clearing pass after reset.
module spatial_table_nearest_threat #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  stnt_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output stnt_pkg::out_word_t result
);

	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);

	stnt_pkg::ctrl_t cmd;
	stnt_pkg::stat_t stat;
	logic [CNTW-1:0] count;
	logic [IW-1:0]   best_idx;
	logic [IW-1:0]   last_idx;
	logic [IW-1:0]   rd_addr;

	stnt_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.count      (count),
		.best_idx   (best_idx),
		.last_idx   (last_idx),
		.cmd        (cmd),
		.rd_addr    (rd_addr)
	);

	stnt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.stat         (stat),
		.count        (count),
		.best_idx     (best_idx),
		.last_idx     (last_idx),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

### design/stnt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module stnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

### design/stnt_dp.sv
// Datapath: entry RAM, count and id registers, distance pipeline, result register.
// Depends on stnt_pkg and stnt_ram; driven by stnt_ctrl.
module stnt_dp #(
	parameter int TABLE_DEPTH = 32,
	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNTW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stnt_pkg::in_word_t  item,
	input  stnt_pkg::ctrl_t     cmd,
	input  logic [IW-1:0]       rd_addr,
	output stnt_pkg::stat_t     stat,
	output logic [CNTW-1:0]     count,
	output logic [IW-1:0]       best_idx,
	output logic [IW-1:0]       last_idx,
	output stnt_pkg::out_word_t result,
	output logic                result_valid,
	input  logic                result_ready
);

	localparam int C  = stnt_pkg::COORD_BITS;
	localparam int DB = stnt_pkg::DIST_BITS;

	stnt_pkg::cmd_t                cmd_q;
	logic [stnt_pkg::KIND_BITS-1:0] kind_q;
	logic signed [C-1:0]           px_q, py_q, pz_q;
	logic [stnt_pkg::RAD_BITS-1:0] rad_q;
	logic [2*stnt_pkg::RAD_BITS-1:0] rr_q;

	logic [CNTW-1:0]               count_q;
	logic [CNTW-1:0]               wp_q;
	logic [stnt_pkg::UID_BITS-1:0] uid_q;
	logic [stnt_pkg::UID_BITS-1:0] uid_nx;

	stnt_pkg::entry_t              rd_entry;
	stnt_pkg::entry_t              push_entry;
	stnt_pkg::entry_t              wr_data;
	logic                          wr_en;
	logic [IW-1:0]                 wr_addr;
	logic                          keep;
	logic                          prune_wr;

	logic                          valid_s1, valid_s2, valid_s3;
	logic [IW-1:0]                 idx_s1, idx_s2, idx_s3;
	logic [C-1:0]                  ax_s2, ay_s2, az_s2;
	logic [2*C-1:0]                sqx_s3, sqy_s3, sqz_s3;
	logic [DB-1:0]                 dist_sum;

	logic [DB-1:0]                 best_q;
	logic [IW-1:0]                 best_idx_q;
	logic                          hit_q;
	logic                          any_q;
	logic [IW-1:0]                 last_idx_q;

	stnt_pkg::out_word_t           out_q;
	stnt_pkg::out_word_t           out_nx;
	logic                          out_valid_q;

	stnt_ram #(
		.WIDTH ($bits(stnt_pkg::entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	assign uid_nx = uid_q + 1'b1;

	always_comb begin
		push_entry.uid    = uid_nx;
		push_entry.kind   = kind_q;
		push_entry.x      = px_q;
		push_entry.y      = py_q;
		push_entry.z      = pz_q;
		push_entry.radius = rad_q;
		push_entry.active = (kind_q != stnt_pkg::KIND_OBSTACLE);
	end

	assign keep     = !((rd_entry.kind == stnt_pkg::KIND_OBSTACLE) && !rd_entry.active);
	assign prune_wr = valid_s1 && (cmd_q == stnt_pkg::CMD_PRUNE) && keep;
	assign wr_en    = cmd.push_commit || prune_wr;
	assign wr_addr  = cmd.push_commit ? count_q[IW-1:0] : wp_q[IW-1:0];
	assign wr_data  = cmd.push_commit ? push_entry : rd_entry;

	assign dist_sum = DB'(sqx_s3) + DB'(sqy_s3) + DB'(sqz_s3);

	// latch the accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= stnt_pkg::CMD_PUSH;
		end else if (cmd.load) begin
			cmd_q <= item.command;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= item.entity_type;
			px_q   <= item.pos_x;
			py_q   <= item.pos_y;
			pz_q   <= item.pos_z;
			rad_q  <= item.radius;
			rr_q   <= (2*stnt_pkg::RAD_BITS)'(item.radius)
				* (2*stnt_pkg::RAD_BITS)'(item.radius);
		end
	end

	// table state and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			uid_q    <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			hit_q    <= 1'b0;
			any_q    <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1 && (cmd_q == stnt_pkg::CMD_CLOSEST)
				&& (rd_entry.kind == stnt_pkg::KIND_OBSTACLE);
			valid_s3 <= valid_s2;
			if (cmd.push_commit) begin
				count_q <= count_q + 1'b1;
				uid_q   <= uid_nx;
			end else if (cmd.prune_commit) begin
				count_q <= wp_q;
			end
			if (cmd.walk_clear) begin
				hit_q <= 1'b0;
				any_q <= 1'b0;
			end else begin
				if (valid_s3 && (dist_sum < best_q)) begin
					hit_q <= 1'b1;
				end
				if (valid_s1 && (cmd_q == stnt_pkg::CMD_LIST) && (rd_entry.kind == kind_q)) begin
					any_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		ax_s2  <= stnt_pkg::abs_diff(rd_entry.x, px_q);
		ay_s2  <= stnt_pkg::abs_diff(rd_entry.y, py_q);
		az_s2  <= stnt_pkg::abs_diff(rd_entry.z, pz_q);
		sqx_s3 <= (2*C)'(ax_s2) * (2*C)'(ax_s2);
		sqy_s3 <= (2*C)'(ay_s2) * (2*C)'(ay_s2);
		sqz_s3 <= (2*C)'(az_s2) * (2*C)'(az_s2);
		if (cmd.walk_clear) begin
			wp_q   <= '0;
			best_q <= DB'(rr_q);
		end else begin
			if (prune_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (valid_s3 && (dist_sum < best_q)) begin
				best_q     <= dist_sum;
				best_idx_q <= idx_s3;
			end
			if (valid_s1 && (cmd_q == stnt_pkg::CMD_LIST) && (rd_entry.kind == kind_q)) begin
				last_idx_q <= idx_s1;
			end
		end
	end

	// result word
	always_comb begin
		out_nx = '0;
		unique case (cmd.emit)
			stnt_pkg::EMIT_NONE: begin
			end
			stnt_pkg::EMIT_EMPTY: begin
				out_nx.status = cmd.emit_status;
				out_nx.last   = 1'b1;
			end
			stnt_pkg::EMIT_PUSH: begin
				out_nx.status        = stnt_pkg::ST_OK;
				out_nx.found         = 1'b1;
				out_nx.uid           = push_entry.uid;
				out_nx.kind          = push_entry.kind;
				out_nx.out_x         = push_entry.x;
				out_nx.out_y         = push_entry.y;
				out_nx.out_z         = push_entry.z;
				out_nx.safety_radius = push_entry.radius;
				out_nx.active        = push_entry.active;
				out_nx.last          = 1'b1;
			end
			stnt_pkg::EMIT_ENTRY: begin
				out_nx.status        = stnt_pkg::ST_OK;
				out_nx.found         = 1'b1;
				out_nx.uid           = rd_entry.uid;
				out_nx.kind          = rd_entry.kind;
				out_nx.out_x         = rd_entry.x;
				out_nx.out_y         = rd_entry.y;
				out_nx.out_z         = rd_entry.z;
				out_nx.safety_radius = rd_entry.radius;
				out_nx.active        = rd_entry.active;
				out_nx.last          = cmd.emit_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit != stnt_pkg::EMIT_NONE) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != stnt_pkg::EMIT_NONE) begin
			out_q <= out_nx;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

	always_comb begin
		stat.cmd      = cmd_q;
		stat.out_free = !out_valid_q || result_ready;
		stat.busy     = valid_s1 || valid_s2 || valid_s3;
		stat.full     = (count_q == CNTW'(TABLE_DEPTH));
		stat.hit      = hit_q;
		stat.any      = any_q;
		stat.rd_match = (rd_entry.kind == kind_q);
	end

	assign count    = count_q;
	assign best_idx = best_idx_q;
	assign last_idx = last_idx_q;

endmodule

### design/stnt_ctrl.sv
// Controller: sequences push, prune walk, closest search and list emission.
// Depends on stnt_pkg; drives stnt_dp through ctrl_t and reads stat_t.
module stnt_ctrl #(
	parameter int TABLE_DEPTH = 32,
	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNTW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  stnt_pkg::stat_t stat,
	input  logic [CNTW-1:0] count,
	input  logic [IW-1:0]   best_idx,
	input  logic [IW-1:0]   last_idx,
	output stnt_pkg::ctrl_t cmd,
	output logic [IW-1:0]   rd_addr
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_WALK,
		S_DRAIN,
		S_FETCH,
		S_HIT,
		S_LIST,
		S_PUSH,
		S_EMPTY
	} state_t;

	state_t          state_q, state_d;
	logic [CNTW-1:0] idx_q, idx_d;
	logic [CNTW-1:0] idx_nx;

	assign idx_nx     = idx_q + 1'b1;
	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_d         = state_q;
		idx_d           = idx_q;
		rd_addr         = idx_q[IW-1:0];
		cmd             = '0;
		cmd.emit        = stnt_pkg::EMIT_NONE;
		cmd.emit_status = stnt_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (stat.cmd == stnt_pkg::CMD_PUSH) begin
					state_d = S_PUSH;
				end else begin
					cmd.walk_clear = 1'b1;
					idx_d          = '0;
					state_d        = S_WALK;
				end
			end
			S_WALK: begin
				if (idx_q < count) begin
					cmd.issue = 1'b1;
					idx_d     = idx_nx;
				end else begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.busy) begin
					priority if (stat.cmd == stnt_pkg::CMD_CLOSEST && stat.hit) begin
						idx_d   = CNTW'(best_idx);
						state_d = S_FETCH;
					end else if (stat.cmd == stnt_pkg::CMD_LIST && stat.any) begin
						idx_d   = '0;
						state_d = S_FETCH;
					end else begin
						state_d = S_EMPTY;
					end
				end
			end
			S_FETCH: begin
				state_d = (stat.cmd == stnt_pkg::CMD_CLOSEST) ? S_HIT : S_LIST;
			end
			S_HIT: begin
				if (stat.out_free) begin
					cmd.emit      = stnt_pkg::EMIT_ENTRY;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_LIST: begin
				if (stat.rd_match) begin
					if (stat.out_free) begin
						cmd.emit      = stnt_pkg::EMIT_ENTRY;
						cmd.emit_last = (idx_q[IW-1:0] == last_idx);
						if (idx_q[IW-1:0] == last_idx) begin
							state_d = S_IDLE;
						end else begin
							idx_d   = idx_nx;
							rd_addr = idx_nx[IW-1:0];
						end
					end
				end else begin
					idx_d   = idx_nx;
					rd_addr = idx_nx[IW-1:0];
				end
			end
			S_PUSH: begin
				if (stat.out_free) begin
					if (stat.full) begin
						cmd.emit        = stnt_pkg::EMIT_EMPTY;
						cmd.emit_status = stnt_pkg::ST_FULL;
					end else begin
						cmd.push_commit = 1'b1;
						cmd.emit        = stnt_pkg::EMIT_PUSH;
					end
					state_d = S_IDLE;
				end
			end
			S_EMPTY: begin
				if (stat.out_free) begin
					cmd.emit = stnt_pkg::EMIT_EMPTY;
					if (stat.cmd == stnt_pkg::CMD_PRUNE) begin
						cmd.prune_commit = 1'b1;
						cmd.emit_status  = stnt_pkg::ST_OK;
					end else begin
						cmd.emit_status  = stnt_pkg::ST_NONE;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

### test/stnt_checker.sv
// Checker for the spatial entry table: watches the command and result channels,
// predicts the result words of every accepted command and compares them in order.
// Depends on stnt_pkg.
`timescale 1ns / 1ps

module stnt_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  stnt_pkg::in_word_t  item,
	input  logic                result_valid,
	input  logic                result_ready,
	input  stnt_pkg::out_word_t result,
	output int                  errors,
	output int                  pending
);

	localparam int DEPTH = 32;

	stnt_pkg::entry_t    entries [DEPTH];
	int                  entry_total;
	logic [31:0]         uid_seq;
	stnt_pkg::out_word_t due_words [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic void queue_word(input stnt_pkg::out_word_t w);
		due_words = {due_words, w};
	endfunction

	function automatic stnt_pkg::out_word_t empty_word(input stnt_pkg::status_t s);
		stnt_pkg::out_word_t w;
		w = '0;
		w.status = s;
		w.last = 1'b1;
		return w;
	endfunction

	function automatic stnt_pkg::out_word_t entry_word(input stnt_pkg::entry_t e,
		input logic lst);
		stnt_pkg::out_word_t w;
		w.status = stnt_pkg::ST_OK;
		w.found = 1'b1;
		w.uid = e.uid;
		w.kind = e.kind;
		w.out_x = e.x;
		w.out_y = e.y;
		w.out_z = e.z;
		w.safety_radius = e.radius;
		w.active = e.active;
		w.last = lst;
		return w;
	endfunction

	task automatic run_command(input stnt_pkg::in_word_t w);
		stnt_pkg::entry_t e;
		longint unsigned best_d;
		longint unsigned d;
		longint dx;
		longint dy;
		longint dz;
		int best_i;
		int last_i;
		int keep;
		int i;
		case (w.command)
			stnt_pkg::CMD_PUSH: begin
				if (entry_total >= DEPTH) begin
					queue_word(empty_word(stnt_pkg::ST_FULL));
				end else begin
					uid_seq = uid_seq + 32'd1;
					e.uid = uid_seq;
					e.kind = w.entity_type;
					e.x = w.pos_x;
					e.y = w.pos_y;
					e.z = w.pos_z;
					e.radius = w.radius;
					e.active = (w.entity_type != stnt_pkg::KIND_OBSTACLE);
					entries[entry_total] = e;
					entry_total++;
					queue_word(entry_word(e, 1'b1));
				end
			end
			stnt_pkg::CMD_PRUNE: begin
				keep = 0;
				for (i = 0; i < entry_total; i++) begin
					if (!(entries[i].kind == stnt_pkg::KIND_OBSTACLE && !entries[i].active)) begin
						entries[keep] = entries[i];
						keep++;
					end
				end
				entry_total = keep;
				queue_word(empty_word(stnt_pkg::ST_OK));
			end
			stnt_pkg::CMD_CLOSEST: begin
				best_d = longint'(w.radius) * longint'(w.radius);
				best_i = -1;
				for (i = 0; i < entry_total; i++) begin
					if (entries[i].kind == stnt_pkg::KIND_OBSTACLE) begin
						dx = longint'(entries[i].x) - longint'(w.pos_x);
						dy = longint'(entries[i].y) - longint'(w.pos_y);
						dz = longint'(entries[i].z) - longint'(w.pos_z);
						d = dx * dx + dy * dy + dz * dz;
						// strict compare: earliest entry wins a tie
						if (d < best_d) begin
							best_d = d;
							best_i = i;
						end
					end
				end
				if (best_i < 0)
					queue_word(empty_word(stnt_pkg::ST_NONE));
				else
					queue_word(entry_word(entries[best_i], 1'b1));
			end
			stnt_pkg::CMD_LIST: begin
				last_i = -1;
				for (i = 0; i < entry_total; i++)
					if (entries[i].kind == w.entity_type)
						last_i = i;
				if (last_i < 0) begin
					queue_word(empty_word(stnt_pkg::ST_NONE));
				end else begin
					for (i = 0; i <= last_i; i++)
						if (entries[i].kind == w.entity_type)
							queue_word(entry_word(entries[i], i == last_i));
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [63:0] expv,
		input logic [63:0] actv);
		if (actv !== expv) begin
			$error("%s: expected %0h, got %0h", name, expv, actv);
			errors++;
		end
	endtask

	task automatic check_word(input stnt_pkg::out_word_t got);
		stnt_pkg::out_word_t want;
		if (due_words.size() == 0) begin
			$error("result word with nothing expected: %p", got);
			errors++;
		end else begin
			want = due_words.pop_front();
			check_field("status", want.status, got.status);
			check_field("found", want.found, got.found);
			check_field("uid", want.uid, got.uid);
			check_field("kind", want.kind, got.kind);
			check_field("out_x", want.out_x, got.out_x);
			check_field("out_y", want.out_y, got.out_y);
			check_field("out_z", want.out_z, got.out_z);
			check_field("safety_radius", want.safety_radius, got.safety_radius);
			check_field("active", want.active, got.active);
			check_field("last", want.last, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_total = 0;
			uid_seq = '0;
			due_words.delete();
			pending <= 0;
		end else begin
			if (item_valid && item_ready)
				run_command(item);
			if (result_valid && result_ready)
				check_word(result);
			pending <= due_words.size();
		end
	end

endmodule

### test/testbench.sv
// Top of the testbench for spatial_table_nearest_threat: clock, reset, command
// stimulus, result back-pressure, watchdog and verdict.
// Depends on stnt_pkg, the block under test and stnt_checker.
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH        = 32;
	localparam int KEEP_CAP     = 14;
	localparam int RANDOM_ITEMS = 245;
	localparam int HOLD_AFTER   = 80;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 100;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	stnt_pkg::in_word_t  item = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	stnt_pkg::out_word_t result;
	int                  errors;
	int                  pending;
	bit                  no_idle = 1'b0;
	bit                  hold_done = 1'b0;
	int                  n_keep = 0;
	int                  n_obst = 0;

	spatial_table_nearest_threat u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	stnt_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] pick_coord();
		if ($urandom_range(0, 3) != 0)
			return 16'($urandom_range(0, 4000)) - 16'd2000;
		return 16'($urandom);
	endfunction

	function automatic stnt_pkg::in_word_t make_word(input stnt_pkg::cmd_t c,
		input logic [2:0] k, input logic [15:0] x, input logic [15:0] y,
		input logic [15:0] z, input logic [15:0] r);
		stnt_pkg::in_word_t w;
		w.command = c;
		w.entity_type = k;
		w.pos_x = x;
		w.pos_y = y;
		w.pos_z = z;
		w.radius = r;
		return w;
	endfunction

	task automatic offer_word(input stnt_pkg::in_word_t w);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (!item_ready);
		// track occupancy so the table never locks up full of kept entries
		case (w.command)
			stnt_pkg::CMD_PUSH: begin
				if (n_keep + n_obst < DEPTH) begin
					if (w.entity_type == stnt_pkg::KIND_OBSTACLE)
						n_obst++;
					else
						n_keep++;
				end
			end
			stnt_pkg::CMD_PRUNE: n_obst = 0;
			default: ;
		endcase
	endtask

	initial begin
		int gap;
		int got;
		got = 0;
		wait (arst_n === 1'b1);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 5);
			// hold off long enough for the block to back up into its input
			if (got >= HOLD_AFTER && !hold_done) begin
				gap = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			got++;
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		stnt_pkg::in_word_t w;
		int roll;
		int phase;
		int i;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		offer_word(make_word(stnt_pkg::CMD_LIST, 3'd0, 16'h1234, 16'h5678, 16'h9ABC,
			16'hDEF0));
		offer_word(make_word(stnt_pkg::CMD_CLOSEST, 3'd0, 16'h0000, 16'h0000, 16'h0000,
			16'hFFFF));
		offer_word(make_word(stnt_pkg::CMD_PRUNE, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF));
		// coordinate and radius extremes
		offer_word(make_word(stnt_pkg::CMD_PUSH, 3'd0, 16'h8000, 16'h8000, 16'h8000,
			16'h0000));
		offer_word(make_word(stnt_pkg::CMD_PUSH, 3'd7, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'hFFFF));
		offer_word(make_word(stnt_pkg::CMD_PUSH, 3'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h5A5A));
		// zero radius never hits, even at distance zero
		offer_word(make_word(stnt_pkg::CMD_CLOSEST, 3'd5, 16'h8000, 16'h8000, 16'h8000,
			16'h0000));
		offer_word(make_word(stnt_pkg::CMD_CLOSEST, 3'd2, 16'h8000, 16'h8000, 16'h8000,
			16'h0001));
		offer_word(make_word(stnt_pkg::CMD_CLOSEST, 3'd0, 16'h0000, 16'h0000, 16'h0000,
			16'hFFFF));
		// equal distances: earliest wins
		offer_word(make_word(stnt_pkg::CMD_PUSH, 3'd0, 16'd100, 16'h0000, 16'h0000,
			16'h00A5));
		offer_word(make_word(stnt_pkg::CMD_PUSH, 3'd0, -16'sd100, 16'h0000, 16'h0000,
			16'h005A));
		offer_word(make_word(stnt_pkg::CMD_CLOSEST, 3'd0, 16'h0000, 16'h0000, 16'h0000,
			16'd200));
		// distance equal to the radius is out of range
		offer_word(make_word(stnt_pkg::CMD_CLOSEST, 3'd0, 16'h0000, 16'h0000, 16'h0000,
			16'd100));
		offer_word(make_word(stnt_pkg::CMD_CLOSEST, 3'd0, 16'h0000, 16'h0000, 16'h0000,
			16'd101));
		for (i = 1; i <= 6; i++)
			offer_word(make_word(stnt_pkg::CMD_PUSH, 3'(i), pick_coord(), pick_coord(),
				pick_coord(), 16'($urandom)));
		offer_word(make_word(stnt_pkg::CMD_LIST, 3'd3, 16'h0000, 16'h0000, 16'h0000,
			16'h0000));
		offer_word(make_word(stnt_pkg::CMD_LIST, 3'd0, 16'hFFFF, 16'h0000, 16'hFFFF,
			16'hFFFF));
		offer_word(make_word(stnt_pkg::CMD_LIST, 3'd7, 16'h0000, 16'hFFFF, 16'h0000,
			16'h0000));
		offer_word(make_word(stnt_pkg::CMD_PRUNE, 3'd0, 16'h0000, 16'h0000, 16'h0000,
			16'h0000));
		offer_word(make_word(stnt_pkg::CMD_LIST, 3'd0, 16'h0000, 16'h0000, 16'h0000,
			16'h0000));

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			phase = (i / 30) % 4;
			no_idle = ((i / 30) % 3 == 2);
			w = make_word(stnt_pkg::cmd_t'($urandom_range(0, 3)), 3'($urandom),
				pick_coord(), pick_coord(), pick_coord(), 16'($urandom));
			roll = $urandom_range(0, 99);
			case (phase)
				0: w.command = (roll < 95) ? stnt_pkg::CMD_PUSH : stnt_pkg::CMD_CLOSEST;
				1: w.command = (roll < 30) ? stnt_pkg::CMD_PUSH :
					(roll < 75) ? stnt_pkg::CMD_CLOSEST :
					(roll < 95) ? stnt_pkg::CMD_LIST : stnt_pkg::CMD_PRUNE;
				3: w.command = (roll < 60) ? stnt_pkg::CMD_PUSH :
					(roll < 80) ? stnt_pkg::CMD_CLOSEST :
					(roll < 90) ? stnt_pkg::CMD_PRUNE : stnt_pkg::CMD_LIST;
				default: ;
			endcase
			case (w.command)
				stnt_pkg::CMD_PUSH: begin
					if (n_keep < KEEP_CAP && $urandom_range(0, 2) == 0)
						w.entity_type = 3'($urandom_range(1, 7));
					else
						w.entity_type = stnt_pkg::KIND_OBSTACLE;
				end
				stnt_pkg::CMD_CLOSEST: begin
					case ($urandom_range(0, 3))
						0, 1: w.radius = 16'($urandom_range(0, 3000));
						2: w.radius = 16'($urandom);
						default: w.radius = 16'hFFFF;
					endcase
				end
				stnt_pkg::CMD_LIST: begin
					if ($urandom_range(0, 1) == 0)
						w.entity_type = stnt_pkg::KIND_OBSTACLE;
				end
				default: ;
			endcase
			offer_word(w);
		end
		item_valid <= 1'b0;
		no_idle = 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
